[hdl/forward_electron_energy_correction_macros.svh]
// assertion macros for the forward electron energy correction block
`ifndef FORWARD_ELECTRON_ENERGY_CORRECTION_MACROS_SVH
`define FORWARD_ELECTRON_ENERGY_CORRECTION_MACROS_SVH

`ifndef SYNTHESIS
`define FEFC_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("fefc assertion failed");
`define FEFC_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("fefc assertion failed");
`else
`define FEFC_ASSERT_IMPLY(label, clk, rst, cond, expr)
`define FEFC_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

[hdl/fefc_pkg.sv]
// shared types and constants of the forward electron energy correction block
package fefc_pkg;

   localparam int COMP_W       = 24;
   localparam int CODE_W       = 32;
   localparam int COEF_W       = 32;
   localparam int MASS_W       = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int SQ_W         = 48;
   localparam int E2_W         = 49;
   localparam int RAD_W        = 50;
   localparam int ROOT_W       = 25;
   localparam int ACC_W        = 39;
   localparam int ACC_SPLIT    = 20;
   localparam int PP_W         = 45;
   localparam int LANE_LO_W    = 45;
   localparam int LANE_HI_W    = 43;
   localparam int NUM_W        = 64;
   localparam int MAG_W        = 63;
   localparam int DIV_SHIFT    = 8;
   localparam int DVS_W        = 33;
   localparam int REM_W        = 57;
   localparam int ENERGY_FRAC  = 16;
   localparam int LANES        = 3;
   localparam int HORNER_STEPS = 4;
   localparam int SIDE_LEN     = 61;
   localparam int RHO_LEN      = 11;
   localparam int HORNER_TAP   = 32;
   localparam int PIPE_DEPTH   = 64;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = 2;
   localparam int QCNT_W       = 3;
   localparam int FLIGHT_W     = 7;

   localparam logic signed [CODE_W-1:0] ELECTRON_CODE = 32'sd11;
   localparam logic signed [ACC_W-1:0]  ACC_LIMIT     = 39'sd274877906943;
   localparam logic signed [COMP_W-1:0] COMP_MAX      = 24'sh7FFFFF;
   localparam logic signed [COMP_W-1:0] COMP_MIN      = 24'sh800000;

   localparam logic [CSR_IDX_W-1:0] CSR_ELECTRON_MASS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CONST    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_LINEAR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_SQUARE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_CUBE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_FOURTH   = 3'd5;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic [ROOT_W-1:0]        root_type;

   typedef struct packed {
      logic     electron;
      comp_type x;
      comp_type y;
      comp_type z;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   typedef struct packed {
      logic [QCNT_W-1:0] level;
   } front_status_type;

   typedef struct packed {
      logic     live;
      comp_type x;
      comp_type y;
      comp_type z;
   } side_type;

   typedef struct packed {
      logic [MASS_W-1:0]        mass;
      logic signed [COEF_W-1:0] c_const;
      logic signed [COEF_W-1:0] c_linear;
      logic signed [COEF_W-1:0] c_square;
      logic signed [COEF_W-1:0] c_cube;
      logic signed [COEF_W-1:0] c_fourth;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mass:     16'd33,
      c_const:  32'sd350515,
      c_linear: 32'sd17618728,
      c_square: -32'sd303849,
      c_cube:   32'sd51283,
      c_fourth: -32'sd2990
   };

endpackage

[hdl/forward_electron_energy_correction.sv]
// Forward electron energy correction: takes one particle request per cycle while req_stall
// is low and returns one result per request, in order. Electron requests (code 11) with a
// nonzero momentum get the vector rescaled by a fourth-degree polynomial of the energy
// over the momentum magnitude; all others pass unchanged with applied low. The block
// sustains one request per clock while nothing stalls. Results pass the two 25-stage
// square root pipelines and the 25-stage dividers (an overflow check, then one quotient
// bit per stage). A four-entry queue in front lets requests land while the result side
// stalls; the whole back pipeline holds while a result waits to be taken. Coefficients and
// mass come from the csr port and must only change while no request is in flight.
`include "forward_electron_energy_correction_macros.svh"

module forward_electron_energy_correction import fefc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [CODE_W-1:0] req_particle_code,
   input  comp_type                 req_mom_x,
   input  comp_type                 req_mom_y,
   input  comp_type                 req_mom_z,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output comp_type                 rsp_new_x,
   output comp_type                 rsp_new_y,
   output comp_type                 rsp_new_z,
   output logic                     rsp_applied,
   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [COEF_W-1:0]        csr_data
);

   cfg_type               cfg_ff, cfg_in;
   queue_out_type         head;
   front_status_type      front_status;
   logic                  pop;
   logic [FLIGHT_W-1:0]   inflight_ff, inflight_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ELECTRON_MASS: cfg_in.mass     = csr_data[MASS_W-1:0];
            CSR_COEF_CONST:    cfg_in.c_const  = csr_data;
            CSR_COEF_LINEAR:   cfg_in.c_linear = csr_data;
            CSR_COEF_SQUARE:   cfg_in.c_square = csr_data;
            CSR_COEF_CUBE:     cfg_in.c_cube   = csr_data;
            CSR_COEF_FOURTH:   cfg_in.c_fourth = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
      inflight_in = inflight_ff + FLIGHT_W'(req_valid && !req_stall)
                  - FLIGHT_W'(rsp_valid && !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= CFG_RESET;
         inflight_ff <= '0;
      end else begin
         cfg_ff      <= cfg_in;
         inflight_ff <= inflight_in;
      end
   end

   fefc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_particle_code (req_particle_code),
      .req_mom_x         (req_mom_x),
      .req_mom_y         (req_mom_y),
      .req_mom_z         (req_mom_z),
      .pop               (pop),
      .head              (head),
      .status            (front_status)
   );

   fefc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .cfg         (cfg_ff),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_new_x   (rsp_new_x),
      .rsp_new_y   (rsp_new_y),
      .rsp_new_z   (rsp_new_z),
      .rsp_applied (rsp_applied)
   );

   `FEFC_ASSERT_IMPLY(a_flight_bound, clock, reset, 1'b1, inflight_ff <= FLIGHT_W'(QUEUE_DEPTH + PIPE_DEPTH))
   `FEFC_ASSERT_IMPLY(a_no_invented, clock, reset, rsp_valid, inflight_ff != '0)
   `FEFC_ASSERT_IMPLY(a_queue_level, clock, reset, 1'b1, front_status.level <= QCNT_W'(QUEUE_DEPTH))
   `FEFC_ASSERT_NEXT(a_csr_mass, clock, reset, csr_write && csr_index == CSR_ELECTRON_MASS, cfg_ff.mass == $past(csr_data[MASS_W-1:0]))

endmodule

[hdl/fefc_front.sv]
// front end: request queue with particle classification
module fefc_front import fefc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [CODE_W-1:0] req_particle_code,
   input  comp_type                 req_mom_x,
   input  comp_type                 req_mom_y,
   input  comp_type                 req_mom_z,
   input  logic                     pop,
   output queue_out_type            head,
   output front_status_type         status
);

   item_type          slot_ff [QUEUE_DEPTH];
   item_type          item_in;
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] level_ff, level_in;
   logic              push;
   logic              pull;

   always_comb begin
      item_in.electron = (req_particle_code == ELECTRON_CODE);
      item_in.x        = req_mom_x;
      item_in.y        = req_mom_y;
      item_in.z        = req_mom_z;
      req_stall        = (level_ff == QCNT_W'(QUEUE_DEPTH));
      push             = req_valid && !req_stall;
      pull             = pop && (level_ff != '0);
      wr_ptr_in        = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in        = pull ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      level_in         = level_ff + QCNT_W'(push) - QCNT_W'(pull);
      head.valid       = (level_ff != '0);
      head.item        = slot_ff[rd_ptr_ff];
      status.level     = level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

[hdl/fefc_isqrt.sv]
// pipelined integer square root, one root bit per stage
module fefc_isqrt import fefc_pkg::*; (
   input  logic             clock,
   input  logic             advance,
   input  logic [RAD_W-1:0] radicand,
   output root_type         root
);

   logic [RAD_W-1:0] rem_ff  [ROOT_W];
   root_type         root_ff [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_step
      localparam int K = ROOT_W - 1 - j;
      logic [RAD_W-1:0] rem_prev, rem_in;
      root_type         root_prev, root_in;
      logic [RAD_W+1:0] trial;

      if (j == 0) begin : g_first
         assign rem_prev  = radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
      end

      always_comb begin
         trial   = ({(RAD_W + 2 - ROOT_W)'(0), root_prev} << (K + 1))
                 + ((RAD_W + 2)'(1) << (2 * K));
         rem_in  = rem_prev;
         root_in = root_prev;
         if ({2'b00, rem_prev} >= trial) begin
            rem_in  = rem_prev - trial[RAD_W-1:0];
            root_in = root_prev | (ROOT_W'(1) << K);
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

[hdl/fefc_horner.sv]
// one horner step: split multiply, floor shift, coefficient add and clamp
module fefc_horner import fefc_pkg::*; (
   input  logic                     clock,
   input  logic                     advance,
   input  acc_type                  acc_in,
   input  root_type                 energy_in,
   input  logic signed [COEF_W-1:0] coef,
   output acc_type                  acc_out,
   output root_type                 energy_out
);

   logic [PP_W-1:0]                  lo_in, lo_ff;
   logic signed [PP_W-1:0]           hi_in, hi_ff;
   logic signed [ACC_W-ACC_SPLIT-1:0] acc_hi;
   logic signed [ROOT_W:0]           energy_s;
   logic signed [NUM_W-1:0]          prod;
   logic signed [NUM_W-1:0]          sum;
   acc_type                          acc_next;
   acc_type                          acc_ff;
   root_type                         energy_a_ff;
   root_type                         energy_b_ff;

   always_comb begin
      acc_hi   = acc_in[ACC_W-1:ACC_SPLIT];
      energy_s = {1'b0, energy_in};
      lo_in    = PP_W'(acc_in[ACC_SPLIT-1:0]) * PP_W'(energy_in);
      hi_in    = PP_W'(acc_hi) * PP_W'(energy_s);
   end

   always_comb begin
      prod = (NUM_W'(hi_ff) <<< ACC_SPLIT) + $signed(NUM_W'(lo_ff));
      sum  = (prod >>> ENERGY_FRAC) + NUM_W'(coef);
      priority if (sum > NUM_W'(ACC_LIMIT)) begin
         acc_next = ACC_LIMIT;
      end else if (sum < -NUM_W'(ACC_LIMIT)) begin
         acc_next = -ACC_LIMIT;
      end else begin
         acc_next = sum[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
         energy_a_ff <= energy_in;
         acc_ff      <= acc_next;
         energy_b_ff <= energy_a_ff;
      end
   end

   assign acc_out    = acc_ff;
   assign energy_out = energy_b_ff;

endmodule

[hdl/fefc_div.sv]
// pipelined restoring divider with overflow check and signed saturation
module fefc_div import fefc_pkg::*; (
   input  logic             clock,
   input  logic             advance,
   input  logic [MAG_W-1:0] magnitude,
   input  logic             negative,
   input  logic [DVS_W-1:0] divisor,
   output comp_type         quotient
);

   logic [REM_W-1:0]  rem_ff [COMP_W+1];
   logic [COMP_W-1:0] quo_ff [COMP_W+1];
   logic [DVS_W-1:0]  dvs_ff [COMP_W+1];
   logic              neg_ff [COMP_W+1];
   logic              ovf_ff [COMP_W+1];
   logic [COMP_W-1:0] quo_last;

   for (genvar j = 0; j <= COMP_W; j++) begin : g_step
      logic [REM_W-1:0]  rem_in;
      logic [COMP_W-1:0] quo_in;
      logic [DVS_W-1:0]  dvs_in;
      logic              neg_in;
      logic              ovf_in;

      if (j == 0) begin : g_check
         always_comb begin
            ovf_in = (magnitude >= MAG_W'({divisor, COMP_W'(0)}));
            rem_in = magnitude[REM_W-1:0];
            quo_in = '0;
            dvs_in = divisor;
            neg_in = negative;
         end
      end else begin : g_bit
         localparam int K = COMP_W - j;
         logic [REM_W-1:0] trial;
         always_comb begin
            trial  = REM_W'(dvs_ff[j-1]) << K;
            rem_in = rem_ff[j-1];
            quo_in = quo_ff[j-1];
            dvs_in = dvs_ff[j-1];
            neg_in = neg_ff[j-1];
            ovf_in = ovf_ff[j-1];
            if (rem_ff[j-1] >= trial) begin
               rem_in = rem_ff[j-1] - trial;
               quo_in = quo_ff[j-1] | (COMP_W'(1) << K);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j] <= rem_in;
            quo_ff[j] <= quo_in;
            dvs_ff[j] <= dvs_in;
            neg_ff[j] <= neg_in;
            ovf_ff[j] <= ovf_in;
         end
      end
   end

   always_comb begin
      quo_last = quo_ff[COMP_W];
      priority if (ovf_ff[COMP_W]) begin
         quotient = neg_ff[COMP_W] ? COMP_MIN : COMP_MAX;
      end else if (neg_ff[COMP_W]) begin
         quotient = (quo_last > COMP_W'(COMP_MIN)) ? COMP_MIN : comp_type'(-quo_last);
      end else begin
         quotient = quo_last[COMP_W-1] ? COMP_MAX : comp_type'(quo_last);
      end
   end

endmodule

[hdl/fefc_back.sv]
// back end: magnitude, energy, polynomial and rescale pipeline with output register
module fefc_back import fefc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  queue_out_type head,
   input  cfg_type       cfg,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output comp_type      rsp_new_x,
   output comp_type      rsp_new_y,
   output comp_type      rsp_new_z,
   output logic          rsp_applied
);

   logic                      advance;
   logic                      s1_valid_ff;
   item_type                  s1_item_ff;
   logic [SQ_W-1:0]           sq_in [LANES];
   logic [SQ_W-1:0]           sq_ff [LANES];
   comp_type                  head_lane [LANES];
   logic [SQ_W-1:0]           p2_sum;
   logic [2*MASS_W-1:0]       mass_sq;
   logic [E2_W-1:0]           e2_sum;
   logic                      s2_valid_ff;
   side_type                  s2_side_in, s2_side_ff;
   logic [SQ_W-1:0]           p2_ff;
   logic [E2_W-1:0]           e2_ff;
   root_type                  rho_root;
   root_type                  energy_root;
   logic [SIDE_LEN-1:0]       side_valid_ff;
   side_type                  side_ff [SIDE_LEN];
   root_type                  rho_ff [RHO_LEN];
   acc_type                   acc_chain [HORNER_STEPS+1];
   root_type                  energy_chain [HORNER_STEPS+1];
   logic signed [COEF_W-1:0]  coef_sel [HORNER_STEPS];
   comp_type                  tap_lane [LANES];
   logic [DVS_W-1:0]          divisor;
   comp_type                  quo [LANES];
   logic                      rsp_valid_ff;
   side_type                  out_in, out_ff;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = head.valid && advance;

   // squares of the components
   always_comb begin
      head_lane[0] = head.item.x;
      head_lane[1] = head.item.y;
      head_lane[2] = head.item.z;
      for (int i = 0; i < LANES; i++) begin
         sq_in[i] = SQ_W'(SQ_W'(head_lane[i]) * SQ_W'(head_lane[i]));
      end
   end

   // p squared, energy squared and the electron decision
   always_comb begin
      p2_sum           = sq_ff[0] + sq_ff[1] + sq_ff[2];
      mass_sq          = (2*MASS_W)'(cfg.mass) * (2*MASS_W)'(cfg.mass);
      e2_sum           = E2_W'(p2_sum) + E2_W'(mass_sq);
      s2_side_in.live  = s1_item_ff.electron && (p2_sum != '0);
      s2_side_in.x     = s1_item_ff.x;
      s2_side_in.y     = s1_item_ff.y;
      s2_side_in.z     = s1_item_ff.z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         side_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         s1_valid_ff   <= pop;
         s2_valid_ff   <= s1_valid_ff;
         side_valid_ff <= {side_valid_ff[SIDE_LEN-2:0], s2_valid_ff};
         rsp_valid_ff  <= side_valid_ff[SIDE_LEN-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff <= head.item;
         for (int i = 0; i < LANES; i++) begin
            sq_ff[i] <= sq_in[i];
         end
         s2_side_ff <= s2_side_in;
         p2_ff      <= p2_sum;
         e2_ff      <= e2_sum;
         side_ff[0] <= s2_side_ff;
         for (int i = 1; i < SIDE_LEN; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         rho_ff[0] <= rho_root;
         for (int i = 1; i < RHO_LEN; i++) begin
            rho_ff[i] <= rho_ff[i-1];
         end
         out_ff <= out_in;
      end
   end

   fefc_isqrt u_rho_sqrt (
      .clock    (clock),
      .advance  (advance),
      .radicand ({(RAD_W - SQ_W)'(0), p2_ff}),
      .root     (rho_root)
   );

   fefc_isqrt u_energy_sqrt (
      .clock    (clock),
      .advance  (advance),
      .radicand ({(RAD_W - E2_W)'(0), e2_ff}),
      .root     (energy_root)
   );

   // horner chain, highest coefficient first
   assign coef_sel[0]     = cfg.c_cube;
   assign coef_sel[1]     = cfg.c_square;
   assign coef_sel[2]     = cfg.c_linear;
   assign coef_sel[3]     = cfg.c_const;
   assign acc_chain[0]    = ACC_W'(cfg.c_fourth);
   assign energy_chain[0] = energy_root;

   for (genvar h = 0; h < HORNER_STEPS; h++) begin : g_horner
      fefc_horner u_step (
         .clock      (clock),
         .advance    (advance),
         .acc_in     (acc_chain[h]),
         .energy_in  (energy_chain[h]),
         .coef       (coef_sel[h]),
         .acc_out    (acc_chain[h+1]),
         .energy_out (energy_chain[h+1])
      );
   end

   assign tap_lane[0] = side_ff[HORNER_TAP].x;
   assign tap_lane[1] = side_ff[HORNER_TAP].y;
   assign tap_lane[2] = side_ff[HORNER_TAP].z;
   assign divisor     = {rho_ff[RHO_LEN-1], DIV_SHIFT'(0)};

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [LANE_LO_W-1:0]        plo_in, plo_ff;
      logic signed [LANE_HI_W-1:0]        phi_in, phi_ff;
      logic signed [ACC_W-ACC_SPLIT-1:0]  acc_hi;
      logic signed [ACC_SPLIT:0]          acc_lo;
      logic signed [NUM_W-1:0]            num_in, num_ff;
      logic [MAG_W-1:0]                   mag_in, mag_ff;
      logic                               neg_ff;

      always_comb begin
         acc_hi = acc_chain[HORNER_STEPS][ACC_W-1:ACC_SPLIT];
         acc_lo = {1'b0, acc_chain[HORNER_STEPS][ACC_SPLIT-1:0]};
         plo_in = LANE_LO_W'(acc_lo) * LANE_LO_W'(tap_lane[l]);
         phi_in = LANE_HI_W'(acc_hi) * LANE_HI_W'(tap_lane[l]);
         num_in = (NUM_W'(phi_ff) <<< ACC_SPLIT) + NUM_W'(plo_ff);
         mag_in = num_ff[NUM_W-1] ? MAG_W'(-num_ff) : num_ff[MAG_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            plo_ff <= plo_in;
            phi_ff <= phi_in;
            num_ff <= num_in;
            mag_ff <= mag_in;
            neg_ff <= num_ff[NUM_W-1];
         end
      end

      fefc_div u_div (
         .clock     (clock),
         .advance   (advance),
         .magnitude (mag_ff),
         .negative  (neg_ff),
         .divisor   (divisor),
         .quotient  (quo[l])
      );
   end

   always_comb begin
      out_in.live = side_ff[SIDE_LEN-1].live;
      out_in.x    = side_ff[SIDE_LEN-1].live ? quo[0] : side_ff[SIDE_LEN-1].x;
      out_in.y    = side_ff[SIDE_LEN-1].live ? quo[1] : side_ff[SIDE_LEN-1].y;
      out_in.z    = side_ff[SIDE_LEN-1].live ? quo[2] : side_ff[SIDE_LEN-1].z;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_new_x   = out_ff.x;
   assign rsp_new_y   = out_ff.y;
   assign rsp_new_z   = out_ff.z;
   assign rsp_applied = out_ff.live;

endmodule

[tb/fefc_checker.sv]
// checker for the forward electron energy correction block: predicts and compares results
`timescale 1ns / 100ps

module fefc_checker import fefc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [CODE_W-1:0] req_particle_code,
   input  comp_type                 req_mom_x,
   input  comp_type                 req_mom_y,
   input  comp_type                 req_mom_z,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  comp_type                 rsp_new_x,
   input  comp_type                 rsp_new_y,
   input  comp_type                 rsp_new_z,
   input  logic                     rsp_applied,
   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [COEF_W-1:0]        csr_data,
   output int                       error_count,
   output int                       pending_count,
   output int                       corrected_count
);

   typedef struct packed {
      comp_type x;
      comp_type y;
      comp_type z;
      logic     applied;
   } momentum_type;

   cfg_type      cfg;
   momentum_type corrected_queue[$];

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] root;
      logic [63:0] bit_val;
      root = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > n) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (n >= root + bit_val) begin
            n = n - (root + bit_val);
            root = (root >> 1) + bit_val;
         end else begin
            root = root >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return root;
   endfunction

   function automatic longint horner_stage(longint acc, longint energy, longint coef);
      longint lim;
      longint v;
      lim = 64'sd274877906943;
      v = ((acc * energy) >>> 16) + coef;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v;
   endfunction

   function automatic momentum_type correct_momentum(logic signed [CODE_W-1:0] code,
                                                      comp_type x, comp_type y, comp_type z);
      momentum_type r;
      longint       comp[3];
      longint       p2, rho, energy, acc, q;
      logic [63:0]  mass;
      r = '{x: x, y: y, z: z, applied: 1'b0};
      comp[0] = x;
      comp[1] = y;
      comp[2] = z;
      p2 = comp[0] * comp[0] + comp[1] * comp[1] + comp[2] * comp[2];
      if (code == ELECTRON_CODE && p2 != 0) begin
         mass = cfg.mass;
         rho = int_sqrt(p2);
         energy = int_sqrt(p2 + mass * mass);
         acc = cfg.c_fourth;
         acc = horner_stage(acc, energy, cfg.c_cube);
         acc = horner_stage(acc, energy, cfg.c_square);
         acc = horner_stage(acc, energy, cfg.c_linear);
         acc = horner_stage(acc, energy, cfg.c_const);
         for (int i = 0; i < 3; i++) begin
            q = (acc * comp[i]) / (rho * 256);
            if (q > 8388607) q = 8388607;
            if (q < -8388608) q = -8388608;
            comp[i] = q;
         end
         r = '{x: comp[0][23:0], y: comp[1][23:0], z: comp[2][23:0], applied: 1'b1};
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   assign pending_count = corrected_queue.size();

   always @(posedge clock) begin
      momentum_type want;
      if (reset) begin
         cfg <= CFG_RESET;
         error_count <= 0;
         corrected_count <= 0;
         corrected_queue.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ELECTRON_MASS: cfg.mass <= csr_data[MASS_W-1:0];
               CSR_COEF_CONST:    cfg.c_const <= csr_data;
               CSR_COEF_LINEAR:   cfg.c_linear <= csr_data;
               CSR_COEF_SQUARE:   cfg.c_square <= csr_data;
               CSR_COEF_CUBE:     cfg.c_cube <= csr_data;
               CSR_COEF_FOURTH:   cfg.c_fourth <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            corrected_queue.push_back(correct_momentum(req_particle_code, req_mom_x,
                                                       req_mom_y, req_mom_z));
         if (rsp_valid && !rsp_stall) begin
            if (corrected_queue.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = corrected_queue.pop_front();
               if (rsp_applied) corrected_count <= corrected_count + 1;
               if (rsp_new_x !== want.x) report_mismatch("new_x", rsp_new_x, want.x);
               if (rsp_new_y !== want.y) report_mismatch("new_y", rsp_new_y, want.y);
               if (rsp_new_z !== want.z) report_mismatch("new_z", rsp_new_z, want.z);
               if (rsp_applied !== want.applied)
                  report_mismatch("applied", rsp_applied, want.applied);
            end
         end
      end
   end

endmodule

[tb/tb_top.sv]
// testbench top: stimulus, configuration phases and verdict for the energy correction block
`timescale 1ns / 100ps

module tb_top import fefc_pkg::*; ();

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_stall;
   logic signed [CODE_W-1:0] req_particle_code = 0;
   comp_type                 req_mom_x = 0;
   comp_type                 req_mom_y = 0;
   comp_type                 req_mom_z = 0;
   logic                     rsp_valid;
   logic                     rsp_stall = 0;
   comp_type                 rsp_new_x;
   comp_type                 rsp_new_y;
   comp_type                 rsp_new_z;
   logic                     rsp_applied;
   logic                     csr_write = 0;
   logic [CSR_IDX_W-1:0]     csr_index = 0;
   logic [COEF_W-1:0]        csr_data = 0;
   int                       error_count;
   int                       pending_count;
   int                       corrected_count;
   int                       cycle_count = 0;
   int                       request_count = 0;
   bit                       quiet_phase = 0;
   bit                       hold_done = 0;

   localparam int PHASES = 5;
   localparam int PER_PHASE = 400;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   always #10 clock = ~clock;

   forward_electron_energy_correction uut (.*);

   fefc_checker checker_inst (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // result side stall: one long hold-off, then bursts
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      repeat (300) @(posedge clock);
      rsp_stall <= 1;
      repeat (200) @(posedge clock);
      rsp_stall <= 0;
      hold_done = 1;
      @(posedge clock);
      forever begin
         if (quiet_phase || $urandom_range(0, 3) != 0) begin
            rsp_stall <= 0;
            @(posedge clock);
         end else begin
            n = $urandom_range(1, 12);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
   endtask

   task automatic send_request(logic signed [CODE_W-1:0] code, comp_type x, comp_type y,
                               comp_type z);
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1;
      req_particle_code <= code;
      req_mom_x <= x;
      req_mom_y <= y;
      req_mom_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      request_count++;
   endtask

   function automatic comp_type random_comp();
      case ($urandom_range(0, 3))
         0: return comp_type'($urandom_range(0, 255)) - 128;
         1: return comp_type'($urandom_range(0, 65535 * 4)) - 131072;
         default: return comp_type'($urandom);
      endcase
   endfunction

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic random_config(int phase);
      logic [COEF_W-1:0] extremes[3];
      extremes = '{32'h7FFFFFFF, 32'h80000000, 32'h0};
      case (phase)
         1: begin
            write_reg(CSR_ELECTRON_MASS, 32'hFFFF);
            for (int i = 1; i < 6; i++)
               write_reg(CSR_IDX_W'(CSR_COEF_CONST + i - 1), extremes[0]);
         end
         2: begin
            write_reg(CSR_ELECTRON_MASS, 32'h0);
            for (int i = 1; i < 6; i++)
               write_reg(CSR_IDX_W'(CSR_COEF_CONST + i - 1), extremes[1]);
         end
         3: begin
            write_reg(CSR_ELECTRON_MASS, $urandom);
            for (int i = 1; i < 6; i++)
               write_reg(CSR_IDX_W'(CSR_COEF_CONST + i - 1), $urandom);
            write_reg(CSR_UNUSED_INDEX, $urandom);
         end
         default: begin
            write_reg(CSR_ELECTRON_MASS, COEF_W'(CFG_RESET.mass));
            write_reg(CSR_COEF_CONST, CFG_RESET.c_const);
            write_reg(CSR_COEF_LINEAR, CFG_RESET.c_linear);
            write_reg(CSR_COEF_SQUARE, CFG_RESET.c_square);
            write_reg(CSR_COEF_CUBE, CFG_RESET.c_cube);
            write_reg(CSR_COEF_FOURTH, CFG_RESET.c_fourth);
         end
      endcase
      csr_write <= 0;
   endtask

   initial begin
      logic signed [CODE_W-1:0] code;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, zero magnitude, non-electrons
      send_request(ELECTRON_CODE, 0, 0, 0);
      send_request(ELECTRON_CODE, COMP_MAX, COMP_MAX, COMP_MAX);
      send_request(ELECTRON_CODE, COMP_MIN, COMP_MIN, COMP_MIN);
      send_request(ELECTRON_CODE, COMP_MAX, 0, 0);
      send_request(ELECTRON_CODE, 0, COMP_MIN, 0);
      send_request(ELECTRON_CODE, 0, 0, 1);
      send_request(ELECTRON_CODE, -1, 1, -1);
      send_request(ELECTRON_CODE, 0, 0, 24'sd65536);
      send_request(ELECTRON_CODE, 24'sd131072, -24'sd65536, 24'sd327680);
      send_request(-ELECTRON_CODE, 24'sd1000, 24'sd2000, 24'sd3000);
      send_request(32'sh7FFFFFFF, COMP_MAX, COMP_MIN, 0);
      send_request(32'sh80000000, COMP_MIN, COMP_MAX, -1);
      send_request(0, 0, 0, 0);
      send_request(22, 5, 6, 7);
      drain();
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            random_config(phase);
            @(posedge clock);
         end
         if (phase == PHASES - 1) quiet_phase = 1;
         for (int k = 0; k < PER_PHASE; k++) begin
            case ($urandom_range(0, 7))
               0: code = $urandom;
               1: code = ELECTRON_CODE ^ (32'sd1 << $urandom_range(0, 31));
               default: code = ELECTRON_CODE;
            endcase
            send_request(code, random_comp(), random_comp(), random_comp());
         end
         drain();
      end
      if (!hold_done) $display("long hold-off did not complete");
      $display("sent %0d requests over %0d settings, %0d results corrected",
               request_count, PHASES, corrected_count);
      $display("covered extremes of mass and coefficients, zero vectors and non-electrons");
      if (error_count == 0 && hold_done) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
